[hdl/rfes_pkg.sv]
`timescale 1ns / 1ps

package rfes_pkg;

  localparam int unsigned QueueAwDef = 3;
  localparam int unsigned MaxResults = 4;

  typedef logic [2:0] phase_t;

  localparam phase_t PhMeta = 3'd0;
  localparam phase_t PhRhdr = 3'd1;
  localparam phase_t PhUl   = 3'd2;
  localparam phase_t PhDl   = 3'd3;
  localparam phase_t PhDone = 3'd4;

  localparam logic [7:0] MetaCountMask = 8'h07;
  localparam logic [7:0] HiPairMask    = 8'hC0;
  localparam logic [7:0] DlCountMask   = 8'h0E;
  localparam logic [7:0] UlTopMask     = 8'h01;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] section;
    logic       field_end;
    logic       structure_end;
  } result_t;

  // Up to four results written into the output queue in one cycle.
  typedef struct packed {
    logic [2:0]                      count;
    result_t [MaxResults-1:0]        entry;
  } push_t;

  function automatic logic [3:0] sect_len(phase_t ph);
    logic [3:0] len;
    unique case (ph)
      PhMeta:  len = 4'd3;
      PhRhdr:  len = 4'd1;
      PhUl:    len = 4'd10;
      default: len = 4'd4;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] field_width(phase_t ph, logic [3:0] st);
    logic [2:0] w;
    w = 3'd1;
    unique case (ph)
      PhMeta: begin
        case (st)
          4'd1:    w = 3'd2;
          default: w = 3'd1;
        endcase
      end
      PhRhdr: w = 3'd4;
      PhUl: begin
        case (st) inside
          4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8: w = 3'd2;
          default:                            w = 3'd1;
        endcase
      end
      default: begin
        case (st)
          4'd0:    w = 3'd2;
          4'd2:    w = 3'd4;
          default: w = 3'd1;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hold_byte(logic [23:0] hold, logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = hold[7:0];
      2'd1:    b = hold[15:8];
      default: b = hold[23:16];
    endcase
    return b;
  endfunction

endpackage

[hdl/rfes_parser.sv]
`timescale 1ns / 1ps

module rfes_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            space_ok_i,
  output rfes_pkg::push_t push_o
);
  import rfes_pkg::*;

  phase_t      phase_q, phase_d;
  logic [3:0]  step_q, step_d;
  logic [1:0]  fill_q, fill_d;
  logic [23:0] hold_q, hold_d;
  logic [4:0]  records_q, records_d;
  logic [2:0]  ul_q, ul_d;
  logic [2:0]  dl_q, dl_d;

  logic        accept;
  logic [2:0]  width;
  logic [3:0]  step_inc;
  logic        go_entry;
  logic        go_record;
  logic        ended;
  logic [1:0]  sel;
  logic [7:0]  r1, r2;

  assign accept     = in_valid_i && space_ok_i;
  assign in_stall_o = !space_ok_i;
  assign width      = field_width(phase_q, step_q);
  assign step_inc   = step_q + 4'd1;
  assign r1         = hold_q[23:16];
  assign r2         = hold_q[15:8];

  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    fill_d    = fill_q;
    hold_d    = hold_q;
    records_d = records_q;
    ul_d      = ul_q;
    dl_d      = dl_q;
    go_entry  = 1'b0;
    go_record = 1'b0;
    ended     = 1'b0;
    sel       = 2'd0;
    push_o    = '0;

    if (accept && phase_q <= PhDl) begin
      if ({1'b0, fill_q} + 3'd1 < width) begin
        case (fill_q)
          2'd0:    hold_d[7:0]   = hold_q[7:0] | in_byte_i;
          2'd1:    hold_d[15:8]  = hold_q[15:8] | in_byte_i;
          default: hold_d[23:16] = hold_q[23:16] | in_byte_i;
        endcase
        fill_d = fill_q + 2'd1;
      end else begin
        if (phase_q == PhMeta && step_q == 4'd1) begin
          records_d = {in_byte_i[2:0] & MetaCountMask[2:0], hold_q[7:6] & HiPairMask[7:6]};
        end
        if (phase_q == PhRhdr) begin
          ul_d = {r1[0] & UlTopMask[0], r2[7:6] & HiPairMask[7:6]};
          dl_d = r1[3:1] & DlCountMask[3:1];
        end
        fill_d = 2'd0;
        hold_d = '0;

        if (step_inc < sect_len(phase_q)) begin
          step_d = step_inc;
        end else begin
          step_d = 4'd0;
          case (phase_q)
            PhMeta: go_record = 1'b1;
            PhUl: begin
              ul_d     = ul_d - 3'd1;
              go_entry = 1'b1;
            end
            PhDl: begin
              dl_d     = dl_d - 3'd1;
              go_entry = 1'b1;
            end
            default: go_entry = 1'b1;
          endcase
        end

        if (go_entry) begin
          if (ul_d != 3'd0) begin
            phase_d = PhUl;
          end else if (dl_d != 3'd0) begin
            phase_d = PhDl;
          end else begin
            go_record = 1'b1;
          end
        end
        if (go_record) begin
          if (records_d == 5'd0) begin
            phase_d = PhDone;
            ended   = 1'b1;
          end else begin
            records_d = records_d - 5'd1;
            phase_d   = PhRhdr;
          end
        end

        // First emitted byte is the newest one; the rest come from the hold
        // register, most significant first.
        push_o.count = width;
        for (int k = 0; k < MaxResults; k++) begin
          sel = 2'(width - 3'(k) - 3'd1);
          push_o.entry[k].data          = (k == 0) ? in_byte_i : hold_byte(hold_q, sel);
          push_o.entry[k].section       = phase_q[1:0];
          push_o.entry[k].field_end     = (3'(k) + 3'd1 == width);
          push_o.entry[k].structure_end = (3'(k) + 3'd1 == width) && ended;
        end
      end
    end

    if (accept && in_last_i) begin
      phase_d   = PhMeta;
      step_d    = 4'd0;
      fill_d    = 2'd0;
      hold_d    = '0;
      records_d = 5'd0;
      ul_d      = 3'd0;
      dl_d      = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhMeta;
      step_q    <= 4'd0;
      fill_q    <= 2'd0;
      hold_q    <= '0;
      records_q <= 5'd0;
      ul_q      <= 3'd0;
      dl_q      <= 3'd0;
    end else begin
      phase_q   <= phase_d;
      step_q    <= step_d;
      fill_q    <= fill_d;
      hold_q    <= hold_d;
      records_q <= records_d;
      ul_q      <= ul_d;
      dl_q      <= dl_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (phase_q == PhMeta && fill_q == 2'd0 && records_q == 5'd0))
    else $error("parser did not restart after last byte");

  a_push_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count != 3'd0) |-> (accept && phase_q <= PhDl))
    else $error("results pushed without an accepted byte");

  a_fill_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q <= PhDl) |-> ({1'b0, fill_q} < width))
    else $error("partial field holds more bytes than its width");

endmodule

[hdl/rfes_out_queue.sv]
`timescale 1ns / 1ps

module rfes_out_queue #(
  parameter int unsigned QueueAw = rfes_pkg::QueueAwDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfes_pkg::push_t   push_i,
  output logic              space_ok_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rfes_pkg::result_t head_o
);
  import rfes_pkg::*;

  localparam int unsigned Depth = 1 << QueueAw;
  localparam int unsigned CntW  = QueueAw + 1;

  result_t             mem_q [Depth];
  logic [QueueAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  assign space_ok_o  = (count_q <= CntW'(Depth - MaxResults));

  assign wr_ptr_d = wr_ptr_q + QueueAw'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + QueueAw'(pop);
  assign count_d  = count_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (3'(k) < push_i.count) begin
        mem_q[wr_ptr_q + QueueAw'(k)] <= push_i.entry[k];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("output queue overflow");

  a_push_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 3'd0) |-> space_ok_o)
    else $error("push into output queue without room");

  a_stalled_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(head_o)))
    else $error("stalled output request changed");

endmodule

[hdl/record_field_endian_swapper.sv]
`timescale 1ns / 1ps

// Byte-stream parser for one nested little-endian log record: a 1/2/1-byte
// metadata header, then records of a 4-byte header plus uplink and downlink
// entries whose counts come from bit fields of the swapped headers. Every
// complete field is re-emitted most significant byte first, one byte per
// output request, tagged with its section and with field and structure end
// flags. The input takes one byte per cycle when not stalled; all bytes of a
// field enter a (1 << QueueAw)-entry output queue at once, as its last input
// byte is accepted, and leave it one per cycle while out_stall_i is low. The
// input stalls whenever that queue has fewer than four free entries, so
// sustained rate is one byte per cycle as long as the output side keeps up.
// A field cut short by in_last_i is dropped, bytes past the end of the
// structure produce nothing, and the parser restarts after every in_last_i byte.

module record_field_endian_swapper #(
  parameter int unsigned QueueAw = rfes_pkg::QueueAwDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] section_o,
  output logic       field_end_o,
  output logic       structure_end_o
);
  import rfes_pkg::*;

  push_t   push;
  logic    space_ok;
  result_t head;

  rfes_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  rfes_out_queue #(
    .QueueAw (QueueAw)
  ) u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_byte_o      = head.data;
  assign section_o       = head.section;
  assign field_end_o     = head.field_end;
  assign structure_end_o = head.structure_end;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import rfes_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] section_o;
  logic       field_end_o;
  logic       structure_end_o;

  record_field_endian_swapper uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .section_o      (section_o),
    .field_end_o    (field_end_o),
    .structure_end_o(structure_end_o)
  );

  always #10 clk_i = ~clk_i;

  raw_byte_t  stream_q[$];
  result_t    swapped_q[$];
  int         mismatches = 0;
  int         accepted_count = 0;
  logic       in_taken = 1'b0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;

  // no idling on either side during this window
  wire calm = (accepted_count >= 150) && (accepted_count < 230);

  // parser state mirror
  phase_t      ph = PhMeta;
  logic [3:0]  step = '0;
  logic [1:0]  fill = '0;
  logic [23:0] hold = '0;
  logic [4:0]  recs = '0;
  logic [2:0]  uls = '0;
  logic [2:0]  dls = '0;

  function automatic int unsigned field_bytes(phase_t p, logic [3:0] s);
    case (p)
      PhMeta: return (s == 4'd1) ? 2 : 1;
      PhRhdr: return 4;
      PhUl: begin
        case (s)
          4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8: return 2;
          default: return 1;
        endcase
      end
      default: begin
        case (s)
          4'd0: return 2;
          4'd2: return 4;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned fields_in(phase_t p);
    case (p)
      PhMeta: return 3;
      PhRhdr: return 1;
      PhUl: return 10;
      default: return 4;
    endcase
  endfunction

  task automatic predict_swap(input logic [7:0] b, input logic last);
    int unsigned w;
    logic [7:0]  fb [4];
    logic        ended;
    logic [1:0]  sec;
    result_t     r;
    if (ph <= PhDl) begin
      w = field_bytes(ph, step);
      if (fill + 1 < w) begin
        hold = hold | ({16'd0, b} << (8 * fill));
        fill = fill + 2'd1;
      end else begin
        sec = ph[1:0];
        fb[0] = b;
        for (int k = 1; k < w; k++) fb[k] = 8'(hold >> (8 * (w - 1 - k)));
        if (ph == PhMeta && step == 4'd1) recs = {b[2:0], hold[7:6]};
        if (ph == PhRhdr) begin
          uls = {hold[16], hold[15:14]};
          dls = hold[19:17];
        end
        fill = '0;
        hold = '0;
        ended = 1'b0;
        step = step + 4'd1;
        if (step >= fields_in(ph)) begin
          step = '0;
          if (ph == PhUl) uls = uls - 3'd1;
          else if (ph == PhDl) dls = dls - 3'd1;
          if (ph != PhMeta && uls != 0) ph = PhUl;
          else if (ph != PhMeta && dls != 0) ph = PhDl;
          else if (recs == 0) begin
            ph = PhDone;
            ended = 1'b1;
          end else begin
            recs = recs - 5'd1;
            ph = PhRhdr;
          end
        end
        for (int k = 0; k < w; k++) begin
          r.data = fb[k];
          r.section = sec;
          r.field_end = (k == w - 1);
          r.structure_end = (k == w - 1) && ended;
          swapped_q.push_back(r);
        end
      end
    end
    if (last) begin
      ph = PhMeta;
      step = '0;
      fill = '0;
      hold = '0;
      recs = '0;
      uls = '0;
      dls = '0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    raw_byte_t item;
    item.data = b;
    item.last = last;
    stream_q.push_back(item);
  endtask

  // One buffer holding a nested record with random content. Entry counts are
  // drawn up to max_ent, or pinned to it when all_max is set. With cut set the
  // buffer ends early; tail adds bytes past the structure.
  task automatic queue_record_buffer(input int unsigned n_rec, input int unsigned max_ent,
                                     input logic all_max, input logic cut,
                                     input int unsigned tail);
    logic [7:0]  raw [$];
    logic [4:0]  nr;
    logic [2:0]  ul;
    logic [2:0]  dl;
    int unsigned len;
    nr = 5'(n_rec);
    raw.push_back(8'($urandom_range(255)));
    raw.push_back({nr[1:0], 6'($urandom_range(63))});
    raw.push_back({5'($urandom_range(31)), nr[4:2]});
    raw.push_back(8'($urandom_range(255)));
    for (int r = 0; r < n_rec; r++) begin
      ul = all_max ? 3'(max_ent) : 3'($urandom_range(max_ent));
      dl = all_max ? 3'(max_ent) : 3'($urandom_range(max_ent));
      raw.push_back(8'($urandom_range(255)));
      raw.push_back({ul[1:0], 6'($urandom_range(63))});
      raw.push_back({4'($urandom_range(15)), dl, ul[2]});
      raw.push_back(8'($urandom_range(255)));
      repeat (16 * ul) raw.push_back(8'($urandom_range(255)));
      repeat (8 * dl) raw.push_back(8'($urandom_range(255)));
    end
    repeat (tail) raw.push_back(8'($urandom_range(255)));
    len = cut ? $urandom_range(raw.size() - 1, 1) : raw.size();
    for (int i = 0; i < len; i++) queue_byte(raw[i], i == len - 1);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned n;
    // zero records with extreme bytes, then a byte past the structure
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h3F, 1'b0);
    queue_byte(8'hF8, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hAA, 1'b1);
    // buffer ends inside the two-byte metadata field
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h11, 1'b1);
    // one record, no uplinks, one downlink entry; last lands on a field end
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h40, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h33, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'hDC, 1'b0);
    queue_byte(8'hBA, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h55, 1'b1);

    n = stream_q.size();
    queue_record_buffer(31, 0, 1'b1, 1'b0, 0);
    while (stream_q.size() - n < 230) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        queue_record_buffer($urandom_range(3), 2, 1'b0, 1'b0, $urandom_range(3));
      end else if (kind < 70) begin
        queue_record_buffer(1, 7, 1'b0, 1'b0, 0);
      end else if (kind < 85) begin
        queue_record_buffer($urandom_range(3), 2, 1'b0, 1'b1, 0);
      end else begin
        kind = $urandom_range(12, 1);
        for (int i = 0; i < kind; i++)
          queue_byte(8'($urandom_range(255)), ($urandom_range(7) == 0) || (i == kind - 1));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (stream_q.size() != 0 || in_valid_i || swapped_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // sender: holds a stalled request, otherwise offers the next byte or idles
  always @(negedge clk_i) begin : driver
    raw_byte_t item;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (stream_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
        item = stream_q.pop_front();
        in_byte_i <= item.data;
        in_last_i <= item.last;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to fill the output queue
  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && accepted_count >= 60) begin
      hold_done = 1'b1;
      hold_left = 150;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_swap(in_byte_i, in_last_i);
      accepted_count = accepted_count + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (swapped_q.size() == 0) begin
        $error("unexpected output byte %h (section %0d)", out_byte_o, section_o);
        mismatches = mismatches + 1;
      end else begin
        want = swapped_q.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte_o: expected %h, got %h", want.data, out_byte_o);
          mismatches = mismatches + 1;
        end
        if (section_o !== want.section) begin
          $error("section_o: expected %0d, got %0d", want.section, section_o);
          mismatches = mismatches + 1;
        end
        if (field_end_o !== want.field_end) begin
          $error("field_end_o: expected %b, got %b", want.field_end, field_end_o);
          mismatches = mismatches + 1;
        end
        if (structure_end_o !== want.structure_end) begin
          $error("structure_end_o: expected %b, got %b", want.structure_end,
                 structure_end_o);
          mismatches = mismatches + 1;
        end
      end
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

endmodule

[sim.f]
hdl/rfes_pkg.sv
hdl/rfes_parser.sv
hdl/rfes_out_queue.sv
hdl/record_field_endian_swapper.sv
tb/sv/testbench.sv
